[rtl/speq_pkg.sv]
// shared constants, types and codes for the stereo parametric eq section
// no dependencies; imported by speq_ctrl, speq_dp and the top level
package speq_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_FRAC   = 22;
  localparam int CHANNELS    = 2;
  localparam int COEF_BITS   = 25;
  localparam int STATE_BITS  = 32;

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TDATA_W   = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_C1 = 3'd0,
    REG_START_C2 = 3'd1,
    REG_START_GG = 3'd2,
    REG_STEP_C1  = 3'd3,
    REG_STEP_C2  = 3'd4,
    REG_STEP_GG  = 3'd5,
    REG_SMOOTH   = 3'd6
  } cfg_reg_t;

  // one multiply-and-update step of the lattice section
  typedef enum logic [2:0] {
    STEP_Y,
    STEP_T,
    STEP_OUT,
    STEP_Y2,
    STEP_Z2
  } step_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic            load;
    logic            mul;
    logic            acc;
    logic            emit;
    step_t           step;
    logic [CH_W-1:0] ch;
  } eq_cmd_t;

  typedef struct packed {
    logic out_free;
  } eq_status_t;

endpackage

[rtl/stereo_parametric_eq_section_core.sv]
// top level of the stereo parametric eq section
// depends on speq_pkg, speq_ctrl and speq_dp
//
// Stereo second-order allpass-lattice peaking section, Q22 coefficients
// shared by both channels, 24-bit samples in and saturated 24-bit samples
// out, one output frame per input frame with tlast passed through. Each
// frame is accepted, then runs five multiplies per channel on the single
// shared multiplier, each a product step (ST_MUL) and an update step
// (ST_ACC), then waits in ST_FINISH until the output register is free and
// loads it; only then is the next frame accepted. The output register lets
// a new frame be taken while the previous result still waits. Writing a
// start value loads the running coefficient. With smooth_mode set, every
// frame first adds the step values to the running coefficients, saturating
// at 25 bits; a configuration write as a frame is accepted skips that ramp.
module stereo_parametric_eq_section_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [speq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [speq_pkg::COEF_BITS-1:0] cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [speq_pkg::TDATA_W-1:0]   s_axis_tdata,  // left_in, right_in
  input  logic                           s_axis_tlast,  // block_end_in
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [speq_pkg::TDATA_W-1:0]   m_axis_tdata,  // left_out, right_out
  output logic                           m_axis_tlast   // block_end_out
);
  import speq_pkg::*;

  eq_cmd_t    cmd;
  eq_status_t status;

  speq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  speq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

[rtl/speq_ctrl.sv]
// sequencer for the eq section: walks five multiply steps per channel
// depends on speq_pkg; drives speq_dp through eq_cmd_t
module speq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  speq_pkg::eq_status_t status,
  output speq_pkg::eq_cmd_t    cmd
);
  import speq_pkg::*;

  ctrl_state_t     state, state_next;
  step_t           step, step_next;
  logic [CH_W-1:0] ch, ch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_Y;
      ch    <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      ch    <= ch_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    ch_next    = ch;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MUL;
          step_next  = STEP_Y;
          ch_next    = '0;
        end
      end
      ST_MUL: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        state_next = ST_MUL;
        case (step)
          STEP_Y:   step_next = STEP_T;
          STEP_T:   step_next = STEP_OUT;
          STEP_OUT: step_next = STEP_Y2;
          STEP_Y2:  step_next = STEP_Z2;
          STEP_Z2: begin
            step_next = STEP_Y;
            if (ch == CH_W'(CHANNELS - 1)) begin
              state_next = ST_FINISH;
            end else begin
              ch_next = ch + 1'b1;
            end
          end
          default:  step_next = STEP_Y;
        endcase
      end
      ST_FINISH: begin
        // hold until the output register can take the frame
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.step  = step;
    cmd.ch    = ch;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL:    cmd.mul  = 1'b1;
      ST_ACC:    cmd.acc  = 1'b1;
      ST_FINISH: cmd.emit = status.out_free;
      default: ;
    endcase
  end

endmodule

[rtl/speq_dp.sv]
// datapath of the eq section: coefficient registers, shared multiplier,
// lattice state per channel and the output register; depends on speq_pkg
module speq_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [speq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [speq_pkg::COEF_BITS-1:0] cfg_data,
  input  logic [speq_pkg::TDATA_W-1:0]   in_data,
  input  logic                           in_last,
  input  speq_pkg::eq_cmd_t              cmd,
  output speq_pkg::eq_status_t           status,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [speq_pkg::TDATA_W-1:0]   out_data,
  output logic                           out_last
);
  import speq_pkg::*;

  localparam int T_W   = STATE_BITS + 2;
  localparam int P_W   = COEF_BITS + T_W;
  localparam int EXT_W = P_W + 1;

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    hi = v >>> (STATE_BITS - 1);
    if (hi == '0 || hi == '1) return v[STATE_BITS-1:0];
    return v[EXT_W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}} : {1'b0, {(STATE_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi;
    hi = v >>> (SAMPLE_BITS - 1);
    if (hi == '0 || hi == '1) return v[SAMPLE_BITS-1:0];
    return v[EXT_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  endfunction

  function automatic logic signed [COEF_BITS-1:0] sat_coef(
    input logic signed [COEF_BITS:0] v);
    if (v[COEF_BITS] == v[COEF_BITS-1]) return v[COEF_BITS-1:0];
    return v[COEF_BITS] ? {1'b1, {(COEF_BITS-1){1'b0}}} : {1'b0, {(COEF_BITS-1){1'b1}}};
  endfunction

  logic signed [COEF_BITS-1:0]   run_c1, run_c2, run_gg;
  logic signed [COEF_BITS-1:0]   step_c1, step_c2, step_gg;
  logic                          smooth_mode;
  logic signed [SAMPLE_BITS-1:0] x_reg [CHANNELS];
  logic signed [SAMPLE_BITS-1:0] o_reg [CHANNELS];
  logic signed [STATE_BITS-1:0]  z1 [CHANNELS];
  logic signed [STATE_BITS-1:0]  z2 [CHANNELS];
  logic signed [STATE_BITS-1:0]  y_reg, y2_reg;
  logic signed [T_W-1:0]         t_reg;
  logic                          last_reg;
  logic signed [P_W-1:0]         prod_reg;

  logic signed [COEF_BITS-1:0]   mul_a;
  logic signed [T_W-1:0]         mul_b;
  logic signed [P_W-1:0]         mul_res;
  logic signed [P_W-1:0]         shifted;
  logic signed [STATE_BITS-1:0]  q;
  logic signed [SAMPLE_BITS-1:0] x_cur;
  logic signed [STATE_BITS-1:0]  z1_cur, z2_cur;
  logic [TDATA_W-1:0]            o_packed;

  assign x_cur  = x_reg[cmd.ch];
  assign z1_cur = z1[cmd.ch];
  assign z2_cur = z2[cmd.ch];

  // operand selection for the shared multiplier
  always_comb begin
    case (cmd.step)
      STEP_Y:   begin mul_a = run_c2; mul_b = T_W'(z2_cur); end
      STEP_T:   begin mul_a = run_c2; mul_b = T_W'(y_reg);  end
      STEP_OUT: begin mul_a = run_gg; mul_b = t_reg;        end
      STEP_Y2:  begin mul_a = run_c1; mul_b = T_W'(z1_cur); end
      STEP_Z2:  begin mul_a = run_c1; mul_b = T_W'(y2_reg); end
      default:  begin mul_a = run_c1; mul_b = '0;           end
    endcase
  end

  assign mul_res = mul_a * mul_b;
  // floor shift of the registered product back to the value scale
  assign shifted = prod_reg >>> COEF_FRAC;
  assign q       = sat_state(EXT_W'(shifted));

  always_comb begin
    o_packed = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      o_packed[c*SAMPLE_BITS +: SAMPLE_BITS] = o_reg[c];
    end
  end

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_c1      <= '0;
      run_c2      <= '0;
      run_gg      <= '0;
      step_c1     <= '0;
      step_c2     <= '0;
      step_gg     <= '0;
      smooth_mode <= 1'b0;
      out_valid   <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        z1[c] <= '0;
        z2[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_C1: run_c1      <= cfg_data;
          REG_START_C2: run_c2      <= cfg_data;
          REG_START_GG: run_gg      <= cfg_data;
          REG_STEP_C1:  step_c1     <= cfg_data;
          REG_STEP_C2:  step_c2     <= cfg_data;
          REG_STEP_GG:  step_gg     <= cfg_data;
          REG_SMOOTH:   smooth_mode <= cfg_data[0];
          default: ;
        endcase
      end else if (cmd.load && smooth_mode) begin
        // coefficient ramp, once per frame before filtering
        run_c1 <= sat_coef((COEF_BITS+1)'(run_c1) + (COEF_BITS+1)'(step_c1));
        run_c2 <= sat_coef((COEF_BITS+1)'(run_c2) + (COEF_BITS+1)'(step_c2));
        run_gg <= sat_coef((COEF_BITS+1)'(run_gg) + (COEF_BITS+1)'(step_gg));
      end

      if (cmd.acc && cmd.step == STEP_Z2) begin
        z2[cmd.ch] <= sat_state(EXT_W'(z1_cur) + EXT_W'(q));
        z1[cmd.ch] <= y2_reg;
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < CHANNELS; c++) begin
        x_reg[c] <= in_data[c*SAMPLE_BITS +: SAMPLE_BITS];
      end
      last_reg <= in_last;
    end
    if (cmd.mul) begin
      prod_reg <= mul_res;
    end
    if (cmd.acc) begin
      case (cmd.step)
        STEP_Y:   y_reg  <= sat_state(EXT_W'(x_cur) - EXT_W'(q));
        STEP_T:   t_reg  <= T_W'(z2_cur) + T_W'(q) - T_W'(x_cur);
        STEP_OUT: o_reg[cmd.ch] <= sat_sample(EXT_W'(x_cur) - EXT_W'(shifted));
        STEP_Y2:  y2_reg <= sat_state(EXT_W'(y_reg) - EXT_W'(q));
        default: ;
      endcase
    end
    if (cmd.emit) begin
      out_data <= o_packed;
      out_last <= last_reg;
    end
  end

endmodule
